// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the clocked concurrent checks of the collision block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, disabled while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/clbm_pkg.sv
// ----------------------------------------------------------------------------
// clbm_pkg
// Number format, saturating fixed-point helpers and the pipeline record type.
// ----------------------------------------------------------------------------
package clbm_pkg;

    localparam int FRAC = 28;
    localparam int UNIT_STEPS = 32;
    localparam int UNIT_LAT = UNIT_STEPS + 2;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_w;

    localparam t_q Q_MAX   = 32'sh7FFFFFFF;
    localparam t_q Q_MIN   = 32'sh80000000;
    localparam t_q Q_ONE   = 32'sh10000000;
    localparam t_q Q_HALF  = 32'sh08000000;
    localparam t_q Q_NHALF = 32'shF8000000;
    localparam t_q Q_THIRD = 32'sd89478485;
    localparam logic [29:0] RELAX_RESET = 30'd536865358;

    function automatic t_w wx(input t_q x);
        return t_w'(x);
    endfunction

    function automatic t_q sat(input t_w x);
        if (x > wx(Q_MAX)) begin
            return Q_MAX;
        end
        if (x < wx(Q_MIN)) begin
            return Q_MIN;
        end
        return t_q'(x);
    endfunction

    // product rounded to FRAC bits, ties toward +inf
    function automatic t_q qmul(input t_q a, input t_q b);
        t_w p;
        p = wx(a) * wx(b);
        return sat((p + wx(Q_HALF)) >>> FRAC);
    endfunction

    function automatic t_q rnd_q(input t_w x);
        return sat((x + t_w'(2)) >>> 2);
    endfunction

    function automatic t_q rnd_h(input t_w x);
        return sat((x + t_w'(1)) >>> 1);
    endfunction

    typedef struct packed {
        logic        vld;
        t_q          m0, m1, m2, m3, m4, m6;
        t_q          sx, sy;
        logic [30:0] drag;
        t_q          numx, numy, u, v, uu, vv;
        t_q          p_m1v, p_m3v, p_m3u, p_m0v, rho_u, third;
        t_q          a1, a2, tk, s;
        t_q          k2, k6, ut, k4, d26, d62;
        t_q          c4, x2, x6, c2, c6, c4x2, q1, q2, numk;
        t_q          speed, k8, n1x, n1y, n2x, n2y, nsx, nsy;
        t_q          pnyv, pnxv, pnxvv, pc4v, pnxu, pc6v, pc6vv;
        t_q          r1, r2, r3, r6, t7, t8;
        t_q          ur1, ur2, uur1, uur2, ut7, ut8;
        t_q          r4, r5, r7, r8;
    } t_cell;

endpackage

// File: hdl/clbm_div.sv
// ----------------------------------------------------------------------------
// clbm_div
// Pipelined Q3.28 divider: (num * 2^28) / den, truncated, saturated.
// One quotient bit per stage, a new request every enabled cycle.
// ----------------------------------------------------------------------------
module clbm_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  clbm_pkg::t_q  i_num,
    input  clbm_pkg::t_q  i_den,
    output clbm_pkg::t_q  o_quo
);

    localparam int Steps = clbm_pkg::UNIT_STEPS;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
        logic        neg;
        logic        ovf;
        logic        dz;
        logic        npos;
        logic        nneg;
    } t_dstage;

    t_dstage      r_st [Steps+1];
    t_dstage      n_st0;
    clbm_pkg::t_q r_quo;
    clbm_pkg::t_q n_quo;

    always_comb begin
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        mag_n = i_num[31] ? (~i_num + 32'd1) : i_num;
        mag_d = i_den[31] ? (~i_den + 32'd1) : i_den;
        n_st0.rem  = {4'b0, mag_n, 28'b0};
        n_st0.quo  = '0;
        n_st0.den  = mag_d;
        n_st0.neg  = i_num[31] ^ i_den[31];
        // quotient of 2^32 or more saturates either way
        n_st0.ovf  = ({4'b0, mag_n} >= {mag_d, 4'b0});
        n_st0.dz   = (i_den == '0);
        n_st0.npos = !i_num[31] && (i_num != '0);
        n_st0.nneg = i_num[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam int Sh = Steps - 1 - k;
        logic [63:0] w_sub;
        t_dstage     n_step;
        assign w_sub = {32'b0, r_st[k].den} << Sh;
        always_comb begin
            n_step = r_st[k];
            if (r_st[k].rem >= w_sub) begin
                n_step.rem     = r_st[k].rem - w_sub;
                n_step.quo[Sh] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_step;
            end
        end
    end

    always_comb begin
        t_dstage e;
        e = r_st[Steps];
        if (e.dz) begin
            n_quo = e.npos ? clbm_pkg::Q_MAX : (e.nneg ? clbm_pkg::Q_MIN : '0);
        end else if (e.ovf) begin
            n_quo = e.neg ? clbm_pkg::Q_MIN : clbm_pkg::Q_MAX;
        end else if (e.neg) begin
            n_quo = (e.quo > 32'h80000000) ? clbm_pkg::Q_MIN : (~e.quo + 32'd1);
        end else begin
            n_quo = e.quo[31] ? clbm_pkg::Q_MAX : e.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hdl/clbm_sqrt.sv
// ----------------------------------------------------------------------------
// clbm_sqrt
// Pipelined square root: floor(sqrt(s * 2^28)), zero for s <= 0.
// Two radicand bits per stage, a new request every enabled cycle.
// ----------------------------------------------------------------------------
module clbm_sqrt (
    input  logic          i_clk,
    input  logic          i_en,
    input  clbm_pkg::t_q  i_s,
    output clbm_pkg::t_q  o_root
);

    localparam int Steps = clbm_pkg::UNIT_STEPS;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } t_sstage;

    t_sstage      r_st [Steps+1];
    clbm_pkg::t_q r_root;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem <= (i_s > 0) ? {5'b0, i_s[30:0], 28'b0} : 64'd0;
            r_st[0].res <= '0;
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam int Sh = 2 * (Steps - 1 - k);
        logic [63:0] w_bit;
        logic [63:0] w_try;
        assign w_bit = 64'd1 << Sh;
        assign w_try = r_st[k].res + w_bit;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_st[k].rem >= w_try) begin
                    r_st[k+1].rem <= r_st[k].rem - w_try;
                    r_st[k+1].res <= (r_st[k].res >> 1) + w_bit;
                end else begin
                    r_st[k+1].rem <= r_st[k].rem;
                    r_st[k+1].res <= r_st[k].res >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= clbm_pkg::t_q'(r_st[Steps].res[31:0]);
        end
    end

    assign o_root = r_root;

endmodule

// File: hdl/cumulant_lbm_cell_collision.sv
// ----------------------------------------------------------------------------
// cumulant_lbm_cell_collision
// D2Q9 cumulant collision with porous-disk forcing, one lattice cell per request.
// ----------------------------------------------------------------------------
// The pipeline takes one cell request per clock and sustains one cell per
// cycle while the output side does not stall. The latency is set by two
// 32-step units in series: the velocity dividers, then the speed square root
// running beside the fourth-moment divider. A stall on the output side holds
// the whole pipeline with nothing lost. The user must write relax_rate only
// while idle; this is not enforced. All arithmetic is signed Q3.28, saturating.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cumulant_lbm_cell_collision (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [29:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pdf_in_0..pdf_in_8, prev_shift_x, prev_shift_y, drag_coeff, pad bit
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pdf_out_0..pdf_out_8, new_shift_x, new_shift_y
    output logic [351:0] o_m_axis_tdata
);

    localparam int Lat = clbm_pkg::UNIT_LAT;

    logic [29:0]    r_relax;
    clbm_pkg::t_q   r_om1, r_hw;
    clbm_pkg::t_cell r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10;
    clbm_pkg::t_cell r_s11, r_s12, r_s13, r_s14, r_s15, r_s16, r_s17;
    clbm_pkg::t_cell n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10;
    clbm_pkg::t_cell n_s11, n_s12, n_s13, n_s14, n_s15, n_s16, n_s17;
    clbm_pkg::t_cell r_dla [Lat];
    clbm_pkg::t_cell r_dlb [Lat];
    logic [351:0]   r_out, n_out;
    logic           r_out_vld;
    logic           w_en;
    clbm_pkg::t_q   w_f [9];
    clbm_pkg::t_q   w_du, w_dv, w_k8, w_spd;

    assign w_en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax <= clbm_pkg::RELAX_RESET;
        end else if (i_cfg_wr_en) begin
            r_relax <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_om1 <= clbm_pkg::Q_ONE - clbm_pkg::t_q'({2'b0, r_relax});
        r_hw  <= clbm_pkg::qmul(clbm_pkg::Q_HALF, r_om1);
    end

    clbm_div u_div_u (.i_clk(i_clk), .i_en(w_en), .i_num(r_s2.numx), .i_den(r_s2.m0),
                      .o_quo(w_du));
    clbm_div u_div_v (.i_clk(i_clk), .i_en(w_en), .i_num(r_s2.numy), .i_den(r_s2.m0),
                      .o_quo(w_dv));
    clbm_div u_div_k (.i_clk(i_clk), .i_en(w_en), .i_num(r_s10.numk), .i_den(r_s10.m0),
                      .o_quo(w_k8));
    clbm_sqrt u_sqrt (.i_clk(i_clk), .i_en(w_en), .i_s(r_s10.s), .o_root(w_spd));

    // raw moments, velocity numerators
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_f[k] = i_s_axis_tdata[k*32 +: 32];
        end
        n_s1 = r_s1;
        n_s1.vld = i_s_axis_tvalid;
        n_s1.m0 = clbm_pkg::sat(clbm_pkg::wx(w_f[0]) + clbm_pkg::wx(w_f[1])
            + clbm_pkg::wx(w_f[2]) + clbm_pkg::wx(w_f[3]) + clbm_pkg::wx(w_f[4])
            + clbm_pkg::wx(w_f[5]) + clbm_pkg::wx(w_f[6]) + clbm_pkg::wx(w_f[7])
            + clbm_pkg::wx(w_f[8]));
        n_s1.m1 = clbm_pkg::sat(-clbm_pkg::wx(w_f[0]) + clbm_pkg::wx(w_f[2])
            - clbm_pkg::wx(w_f[3]) + clbm_pkg::wx(w_f[5]) - clbm_pkg::wx(w_f[6])
            + clbm_pkg::wx(w_f[8]));
        n_s1.m2 = clbm_pkg::sat(clbm_pkg::wx(w_f[0]) + clbm_pkg::wx(w_f[2])
            + clbm_pkg::wx(w_f[3]) + clbm_pkg::wx(w_f[5]) + clbm_pkg::wx(w_f[6])
            + clbm_pkg::wx(w_f[8]));
        n_s1.m3 = clbm_pkg::sat(-clbm_pkg::wx(w_f[0]) - clbm_pkg::wx(w_f[1])
            - clbm_pkg::wx(w_f[2]) + clbm_pkg::wx(w_f[6]) + clbm_pkg::wx(w_f[7])
            + clbm_pkg::wx(w_f[8]));
        n_s1.m4 = clbm_pkg::sat(clbm_pkg::wx(w_f[0]) - clbm_pkg::wx(w_f[2])
            - clbm_pkg::wx(w_f[6]) + clbm_pkg::wx(w_f[8]));
        n_s1.m6 = clbm_pkg::sat(clbm_pkg::wx(w_f[0]) + clbm_pkg::wx(w_f[1])
            + clbm_pkg::wx(w_f[2]) + clbm_pkg::wx(w_f[6]) + clbm_pkg::wx(w_f[7])
            + clbm_pkg::wx(w_f[8]));
        n_s1.sx = i_s_axis_tdata[319:288];
        n_s1.sy = i_s_axis_tdata[351:320];
        n_s1.drag = i_s_axis_tdata[382:352];

        n_s2 = r_s1;
        n_s2.numx = clbm_pkg::sat(clbm_pkg::wx(r_s1.m3) + clbm_pkg::wx(r_s1.sx));
        n_s2.numy = clbm_pkg::sat(clbm_pkg::wx(r_s1.m1) + clbm_pkg::wx(r_s1.sy));
    end

    // second-order central moments and relaxation
    always_comb begin
        n_s3 = r_dla[Lat-1];
        n_s3.u = w_du;
        n_s3.v = w_dv;
        n_s3.uu = clbm_pkg::qmul(w_du, w_du);
        n_s3.vv = clbm_pkg::qmul(w_dv, w_dv);
        n_s3.p_m1v = clbm_pkg::qmul(r_dla[Lat-1].m1, w_dv);
        n_s3.p_m3v = clbm_pkg::qmul(r_dla[Lat-1].m3, w_dv);
        n_s3.p_m3u = clbm_pkg::qmul(r_dla[Lat-1].m3, w_du);
        n_s3.p_m0v = clbm_pkg::qmul(r_dla[Lat-1].m0, w_dv);
        n_s3.rho_u = clbm_pkg::qmul(r_dla[Lat-1].m0, w_du);
        n_s3.third = clbm_pkg::qmul(r_dla[Lat-1].m0, clbm_pkg::Q_THIRD);

        n_s4 = r_s3;
        n_s4.a1 = clbm_pkg::qmul(r_s3.m0, r_s3.vv);
        n_s4.a2 = clbm_pkg::qmul(r_s3.m0, r_s3.uu);
        n_s4.tk = clbm_pkg::sat(clbm_pkg::wx(r_s3.p_m0v) - clbm_pkg::wx(r_s3.m1));
        n_s4.s  = clbm_pkg::sat(clbm_pkg::wx(r_s3.uu) + clbm_pkg::wx(r_s3.vv));

        n_s5 = r_s4;
        n_s5.k2 = clbm_pkg::sat(clbm_pkg::wx(r_s4.a1) - (clbm_pkg::wx(r_s4.p_m1v) <<< 1)
            + clbm_pkg::wx(r_s4.m2));
        n_s5.k6 = clbm_pkg::sat(clbm_pkg::wx(r_s4.a2) - (clbm_pkg::wx(r_s4.p_m3u) <<< 1)
            + clbm_pkg::wx(r_s4.m6));
        n_s5.ut = clbm_pkg::qmul(r_s4.u, r_s4.tk);

        n_s6 = r_s5;
        n_s6.k4 = clbm_pkg::sat(-clbm_pkg::wx(r_s5.p_m3v) + clbm_pkg::wx(r_s5.m4)
            + clbm_pkg::wx(r_s5.ut));
        n_s6.d26 = clbm_pkg::sat(clbm_pkg::wx(r_s5.k2) - clbm_pkg::wx(r_s5.k6));
        n_s6.d62 = clbm_pkg::sat(clbm_pkg::wx(r_s5.k6) - clbm_pkg::wx(r_s5.k2));

        n_s7 = r_s6;
        n_s7.c4 = clbm_pkg::qmul(r_om1, r_s6.k4);
        n_s7.x2 = clbm_pkg::qmul(r_hw, r_s6.d26);
        n_s7.x6 = clbm_pkg::qmul(r_hw, r_s6.d62);

        n_s8 = r_s7;
        n_s8.c2 = clbm_pkg::sat(clbm_pkg::wx(r_s7.x2) + clbm_pkg::wx(r_s7.third));
        n_s8.c6 = clbm_pkg::sat(clbm_pkg::wx(r_s7.x6) + clbm_pkg::wx(r_s7.third));
        n_s8.c4x2 = clbm_pkg::sat(clbm_pkg::wx(r_s7.c4) <<< 1);

        n_s9 = r_s8;
        n_s9.q1 = clbm_pkg::qmul(r_s8.c4x2, r_s8.c4);
        n_s9.q2 = clbm_pkg::qmul(r_s8.c6, r_s8.c2);

        n_s10 = r_s9;
        n_s10.numk = clbm_pkg::sat(clbm_pkg::wx(r_s9.q1) + clbm_pkg::wx(r_s9.q2));
    end

    // drag shift and back to raw moments
    always_comb begin
        n_s11 = r_dlb[Lat-1];
        n_s11.speed = w_spd;
        n_s11.k8 = w_k8;
        n_s11.n1x = clbm_pkg::qmul(clbm_pkg::Q_NHALF, r_dlb[Lat-1].u);
        n_s11.n1y = clbm_pkg::qmul(clbm_pkg::Q_NHALF, r_dlb[Lat-1].v);

        n_s12 = r_s11;
        n_s12.n2x = clbm_pkg::qmul(r_s11.n1x, r_s11.speed);
        n_s12.n2y = clbm_pkg::qmul(r_s11.n1y, r_s11.speed);

        n_s13 = r_s12;
        n_s13.nsx = clbm_pkg::qmul(r_s12.n2x, clbm_pkg::t_q'({1'b0, r_s12.drag}));
        n_s13.nsy = clbm_pkg::qmul(r_s12.n2y, clbm_pkg::t_q'({1'b0, r_s12.drag}));

        n_s14 = r_s13;
        n_s14.pnyv  = clbm_pkg::qmul(r_s13.nsy, r_s13.v);
        n_s14.pnxv  = clbm_pkg::qmul(r_s13.nsx, r_s13.v);
        n_s14.pnxvv = clbm_pkg::qmul(r_s13.nsx, r_s13.vv);
        n_s14.pc4v  = clbm_pkg::qmul(r_s13.c4, r_s13.v);
        n_s14.pnxu  = clbm_pkg::qmul(r_s13.nsx, r_s13.u);
        n_s14.pc6v  = clbm_pkg::qmul(r_s13.c6, r_s13.v);
        n_s14.pc6vv = clbm_pkg::qmul(r_s13.c6, r_s13.vv);

        n_s15 = r_s14;
        n_s15.r1 = clbm_pkg::sat(clbm_pkg::wx(r_s14.p_m0v) + clbm_pkg::wx(r_s14.nsy));
        n_s15.r2 = clbm_pkg::sat(clbm_pkg::wx(r_s14.a1) + (clbm_pkg::wx(r_s14.pnyv) <<< 1)
            + clbm_pkg::wx(r_s14.c2));
        n_s15.r3 = clbm_pkg::sat(clbm_pkg::wx(r_s14.rho_u) + clbm_pkg::wx(r_s14.nsx));
        n_s15.r6 = clbm_pkg::sat(clbm_pkg::wx(r_s14.a2) + (clbm_pkg::wx(r_s14.pnxu) <<< 1)
            + clbm_pkg::wx(r_s14.c6));
        n_s15.t7 = clbm_pkg::sat(clbm_pkg::wx(r_s14.pnxv) + clbm_pkg::wx(r_s14.c4));
        n_s15.t8 = clbm_pkg::sat(clbm_pkg::wx(r_s14.pnxvv)
            + (clbm_pkg::wx(r_s14.pc4v) <<< 1));

        n_s16 = r_s15;
        n_s16.ur1  = clbm_pkg::qmul(r_s15.u, r_s15.r1);
        n_s16.ur2  = clbm_pkg::qmul(r_s15.u, r_s15.r2);
        n_s16.uur1 = clbm_pkg::qmul(r_s15.uu, r_s15.r1);
        n_s16.uur2 = clbm_pkg::qmul(r_s15.uu, r_s15.r2);
        n_s16.ut7  = clbm_pkg::qmul(r_s15.u, r_s15.t7);
        n_s16.ut8  = clbm_pkg::qmul(r_s15.u, r_s15.t8);

        n_s17 = r_s16;
        n_s17.r4 = clbm_pkg::sat(clbm_pkg::wx(r_s16.pnxv) + clbm_pkg::wx(r_s16.c4)
            + clbm_pkg::wx(r_s16.ur1));
        n_s17.r5 = clbm_pkg::sat(clbm_pkg::wx(r_s16.pnxvv) + (clbm_pkg::wx(r_s16.pc4v) <<< 1)
            + clbm_pkg::wx(r_s16.ur2));
        n_s17.r7 = clbm_pkg::sat(clbm_pkg::wx(r_s16.pc6v) + clbm_pkg::wx(r_s16.uur1)
            + (clbm_pkg::wx(r_s16.ut7) <<< 1));
        n_s17.r8 = clbm_pkg::sat(clbm_pkg::wx(r_s16.pc6vv) + clbm_pkg::wx(r_s16.k8)
            + clbm_pkg::wx(r_s16.uur2) + (clbm_pkg::wx(r_s16.ut8) <<< 1));
    end

    // raw moments to distributions
    always_comb begin
        clbm_pkg::t_w w1, w2, w3, w4, w6, w8;
        w1 = clbm_pkg::wx(r_s17.r1);
        w2 = clbm_pkg::wx(r_s17.r2);
        w3 = clbm_pkg::wx(r_s17.r3);
        w4 = clbm_pkg::wx(r_s17.r4);
        w6 = clbm_pkg::wx(r_s17.r6);
        w8 = clbm_pkg::wx(r_s17.r8);
        n_out[31:0]    = clbm_pkg::rnd_q(w4 - clbm_pkg::wx(r_s17.r5)
            - clbm_pkg::wx(r_s17.r7) + w8);
        n_out[63:32]   = clbm_pkg::rnd_h(-(w3 - clbm_pkg::wx(r_s17.r5) - w6 + w8));
        n_out[95:64]   = clbm_pkg::rnd_q(-(w4 + clbm_pkg::wx(r_s17.r5)
            - clbm_pkg::wx(r_s17.r7) - w8));
        n_out[127:96]  = clbm_pkg::rnd_h(-(w1 - w2 - clbm_pkg::wx(r_s17.r7) + w8));
        n_out[159:128] = clbm_pkg::sat(clbm_pkg::wx(r_s17.m0) - w2 - w6 + w8);
        n_out[191:160] = clbm_pkg::rnd_h(w1 + w2 - clbm_pkg::wx(r_s17.r7) - w8);
        n_out[223:192] = clbm_pkg::rnd_q(-(w4 - clbm_pkg::wx(r_s17.r5)
            + clbm_pkg::wx(r_s17.r7) - w8));
        n_out[255:224] = clbm_pkg::rnd_h(w3 - clbm_pkg::wx(r_s17.r5) + w6 - w8);
        n_out[287:256] = clbm_pkg::rnd_q(w4 + clbm_pkg::wx(r_s17.r5)
            + clbm_pkg::wx(r_s17.r7) + w8);
        n_out[319:288] = r_s17.nsx;
        n_out[351:320] = r_s17.nsy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_s4.vld  <= 1'b0;
            r_s5.vld  <= 1'b0;
            r_s6.vld  <= 1'b0;
            r_s7.vld  <= 1'b0;
            r_s8.vld  <= 1'b0;
            r_s9.vld  <= 1'b0;
            r_s10.vld <= 1'b0;
            r_s11.vld <= 1'b0;
            r_s12.vld <= 1'b0;
            r_s13.vld <= 1'b0;
            r_s14.vld <= 1'b0;
            r_s15.vld <= 1'b0;
            r_s16.vld <= 1'b0;
            r_s17.vld <= 1'b0;
            for (int k = 0; k < Lat; k++) begin
                r_dla[k].vld <= 1'b0;
                r_dlb[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_dla[0] <= r_s2;
            for (int k = 1; k < Lat; k++) begin
                r_dla[k] <= r_dla[k-1];
            end
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_s7  <= n_s7;
            r_s8  <= n_s8;
            r_s9  <= n_s9;
            r_s10 <= n_s10;
            r_dlb[0] <= r_s10;
            for (int k = 1; k < Lat; k++) begin
                r_dlb[k] <= r_dlb[k-1];
            end
            r_s11 <= n_s11;
            r_s12 <= n_s12;
            r_s13 <= n_s13;
            r_s14 <= n_s14;
            r_s15 <= n_s15;
            r_s16 <= n_s16;
            r_s17 <= n_s17;
            r_out <= n_out;
            r_out_vld <= r_s17.vld;
        end
    end

    `ASSERT_IMPL(a_zero_rho_pos, i_clk, i_rst_n,
        r_s3.vld && r_s3.m0 == 0 && r_s3.numx > 0, r_s3.u == clbm_pkg::Q_MAX,
        "zero density with positive momentum must saturate velocity")
    `ASSERT_IMPL(a_speed_low, i_clk, i_rst_n, r_s11.vld && r_s11.s > 0,
        clbm_pkg::t_w'(r_s11.speed) * clbm_pkg::t_w'(r_s11.speed)
            <= (clbm_pkg::t_w'(r_s11.s) <<< clbm_pkg::FRAC),
        "speed root too large")
    `ASSERT_IMPL(a_speed_high, i_clk, i_rst_n, r_s11.vld && r_s11.s > 0,
        (clbm_pkg::t_w'(r_s11.speed) + 1) * (clbm_pkg::t_w'(r_s11.speed) + 1)
            > (clbm_pkg::t_w'(r_s11.s) <<< clbm_pkg::FRAC),
        "speed root too small")
    `ASSERT_PROP(a_stall_hold, i_clk, i_rst_n,
        (r_s17.vld && !w_en) |=> r_s17.vld,
        "stalled pipeline dropped a request")

endmodule
